// ===== design/gpsp_pkg.sv =====
package gpsp_pkg;

  typedef enum logic [1:0] {
    REC_HEADER  = 2'd0,
    REC_SECTION = 2'd1,
    REC_VALUE   = 2'd2,
    REC_END     = 2'd3
  } rec_kind_t;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_UNK_SECTION = 3'd1,
    ST_UNK_VERSION = 3'd2,
    ST_TRUNCATED   = 3'd3,
    ST_OVERFLOW    = 3'd4
  } status_t;

  // Compact record handed from the front to the back.
  // Header:  f0 id low, f1 id high, f2 version byte, f3 patch.
  // Section: f0 section, f1 revision.
  // Value:   f0 section, f1 revision, f2 item code, f3 raw value.
  typedef struct packed {
    rec_kind_t   kind;
    status_t     status;
    logic        eop;
    logic [7:0]  f0;
    logic [7:0]  f1;
    logic [7:0]  f2;
    logic [15:0] f3;
  } qentry_t;

  typedef struct packed {
    logic [7:0] start;
    logic [4:0] count;
  } grp_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int TYPE_ROWS   = 10;
  localparam int ITEM_ROWS   = 158;
  localparam int DIV_ROWS    = 65;

  localparam logic [7:0] SECTION_LAST = 8'hB0;
  localparam logic [7:0] DIV_CODE_LO  = 8'h01;
  localparam logic [7:0] DIV_CODE_HI  = 8'h41;

  // {id low, id high}
  localparam logic [15:0] TYPE_IDS [TYPE_ROWS] = '{
    16'h0200, 16'h0300, 16'h0301, 16'h0a00, 16'h0c00,
    16'h0d04, 16'h1000, 16'h1200, 16'h2900, 16'h3700
  };

  localparam logic [6:0] ITEM_DIV [DIV_ROWS] = '{
    7'd10, 7'd10, 7'd10, 7'd10, 7'd10, 7'd10, 7'd100, 7'd10,
    7'd100, 7'd10, 7'd10, 7'd100, 7'd100, 7'd100, 7'd10, 7'd100,
    7'd10, 7'd100, 7'd10, 7'd100, 7'd10, 7'd1, 7'd10, 7'd10,
    7'd10, 7'd100, 7'd100, 7'd100, 7'd100, 7'd1, 7'd100, 7'd10,
    7'd100, 7'd10, 7'd100, 7'd1, 7'd10, 7'd10, 7'd100, 7'd1,
    7'd100, 7'd1, 7'd10, 7'd10, 7'd10, 7'd10, 7'd10, 7'd10,
    7'd10, 7'd1, 7'd100, 7'd1, 7'd1, 7'd1, 7'd10, 7'd100,
    7'd10, 7'd100, 7'd10, 7'd10, 7'd10, 7'd100, 7'd100, 7'd10,
    7'd10
  };

  localparam logic [7:0] ITEM_CODES [ITEM_ROWS] = '{
    8'h01, 8'h02, 8'h03, 8'h04, 8'h05,
    8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h08, 8'h09,
    8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
    8'h01, 8'h02, 8'h03, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09,
    8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'hff,
    8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h0a,
    8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a,
    8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0b,
    8'h0c, 8'h0a,
    8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h39,
    8'h3a, 8'h3b, 8'h3c,
    8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11,
    8'h0d, 8'h0e, 8'h0f, 8'h10, 8'h11, 8'h12, 8'h3e, 8'h14, 8'h3f,
    8'h16,
    8'h17, 8'h18, 8'h19, 8'h1a, 8'h1b,
    8'h17, 8'h18, 8'h19, 8'h1a, 8'h1b, 8'h40, 8'h41,
    8'h1c, 8'h1d,
    8'h1e, 8'h1f, 8'h20, 8'h21,
    8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22,
    8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23,
    8'h1e, 8'h1f, 8'h20, 8'h21, 8'h3d,
    8'h24, 8'h25, 8'h26, 8'h27,
    8'h24, 8'h25, 8'h26, 8'h27,
    8'h28,
    8'h28, 8'h29,
    8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h2f, 8'h30,
    8'h2a, 8'h2b, 8'h2c, 8'h2d, 8'h2e, 8'h2f, 8'h30, 8'h31,
    8'h32, 8'h33,
    8'h34, 8'h35,
    8'h36, 8'h37, 8'h38
  };

  // First row and row count of each section/version group.
  function automatic grp_t group_lookup(input logic [7:0] sec, input logic [7:0] ver);
    grp_t g;
    case ({sec, ver})
      16'h0000: g = '{8'd0,   5'd5};
      16'h0001: g = '{8'd5,   5'd7};
      16'h0002: g = '{8'd12,  5'd7};
      16'h0003: g = '{8'd19,  5'd8};
      16'h0008: g = '{8'd27,  5'd6};
      16'h000a: g = '{8'd33,  5'd8};
      16'h000b: g = '{8'd41,  5'd10};
      16'h000c: g = '{8'd51,  5'd12};
      16'h0035: g = '{8'd63,  5'd13};
      16'h1000: g = '{8'd76,  5'd5};
      16'h1003: g = '{8'd81,  5'd9};
      16'h2000: g = '{8'd90,  5'd1};
      16'h3003: g = '{8'd91,  5'd5};
      16'h3007: g = '{8'd96,  5'd7};
      16'h4000: g = '{8'd103, 5'd2};
      16'h5000: g = '{8'd105, 5'd4};
      16'h5001: g = '{8'd109, 5'd5};
      16'h5008: g = '{8'd114, 5'd6};
      16'h5011: g = '{8'd120, 5'd5};
      16'h6000: g = '{8'd125, 5'd4};
      16'h6004: g = '{8'd129, 5'd4};
      16'h7000: g = '{8'd133, 5'd1};
      16'h7002: g = '{8'd134, 5'd2};
      16'h8000: g = '{8'd136, 5'd7};
      16'h8001: g = '{8'd143, 5'd8};
      16'h9000: g = '{8'd151, 5'd2};
      16'ha002: g = '{8'd153, 5'd2};
      16'hb000: g = '{8'd155, 5'd3};
      default:  g = '{8'd0,   5'd0};
    endcase
    return g;
  endfunction

  function automatic logic [7:0] item_code_of(input logic [7:0] idx);
    logic [7:0] code;
    code = 8'hff;
    if (idx < 8'(ITEM_ROWS)) begin
      code = ITEM_CODES[idx];
    end
    return code;
  endfunction

  function automatic logic [6:0] divider_of(input logic [7:0] code);
    logic [7:0] off;
    logic [6:0] d;
    off = code - DIV_CODE_LO;
    d = 7'd1;
    if (code >= DIV_CODE_LO && code <= DIV_CODE_HI) begin
      d = ITEM_DIV[off[6:0]];
    end
    return d;
  endfunction

endpackage

// ===== design/gpsp_front.sv =====
module gpsp_front import gpsp_pkg::*; #(
  parameter int MAX_PROFILE_BYTES = 256,
  parameter int ITEM_TABLE_DEPTH  = 158
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  input  logic       in_tlast,
  input  logic       q_full,
  output logic       q_push,
  output qentry_t    q_entry
);

  localparam int PW = $clog2(MAX_PROFILE_BYTES + 1);
  localparam logic [PW-1:0] POS_LIMIT = PW'(MAX_PROFILE_BYTES);
  localparam logic [8:0]    DEPTH9    = 9'(ITEM_TABLE_DEPTH);

  typedef enum logic [2:0] {
    PH_H0, PH_H1, PH_H2, PH_H3, PH_SEC, PH_VER, PH_VHI, PH_VLO
  } phase_t;

  phase_t        phase_r, phase_nxt;
  logic [PW-1:0] pos_r, pos_nxt, pos_cur;
  logic [7:0]    idl_r, idl_nxt, idh_r, idh_nxt, vh_r, vh_nxt;
  logic [7:0]    sec_r, sec_nxt, rev_r, rev_nxt;
  logic [4:0]    items_r, items_nxt;
  logic [7:0]    tp_r, tp_nxt, vhb_r, vhb_nxt;
  logic          stopped_r, stopped_nxt;

  logic          accept, emit, fail;
  status_t       fail_st;
  qentry_t       ent;
  grp_t          grp;
  logic [8:0]    room;
  logic [4:0]    cnt_eff;
  logic [7:0]    code;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // Group lookup, clipped to the rows the item table holds.
  always_comb begin
    grp  = group_lookup(sec_r, in_tdata);
    room = DEPTH9 - {1'b0, grp.start};
    if ({1'b0, grp.start} >= DEPTH9) begin
      cnt_eff = 5'd0;
    end else if ({4'b0, grp.count} > room) begin
      cnt_eff = room[4:0];
    end else begin
      cnt_eff = grp.count;
    end
  end

  assign code = item_code_of(tp_r);

  always_comb begin
    phase_nxt   = phase_r;
    pos_nxt     = pos_r;
    idl_nxt     = idl_r;
    idh_nxt     = idh_r;
    vh_nxt      = vh_r;
    sec_nxt     = sec_r;
    rev_nxt     = rev_r;
    items_nxt   = items_r;
    tp_nxt      = tp_r;
    vhb_nxt     = vhb_r;
    stopped_nxt = stopped_r;
    pos_cur     = pos_r;
    emit        = 1'b0;
    fail        = 1'b0;
    fail_st     = ST_OK;
    ent         = '0;

    if (accept) begin
      if (in_tuser) begin
        phase_nxt   = PH_H0;
        pos_nxt     = '0;
        idl_nxt     = '0;
        idh_nxt     = '0;
        vh_nxt      = '0;
        sec_nxt     = '0;
        rev_nxt     = '0;
        items_nxt   = '0;
        tp_nxt      = '0;
        vhb_nxt     = '0;
        stopped_nxt = 1'b0;
      end
      if (!stopped_nxt) begin
        pos_cur = pos_nxt;
        pos_nxt = pos_cur + PW'(1);
        if (pos_cur >= POS_LIMIT) begin
          fail    = 1'b1;
          fail_st = ST_OVERFLOW;
        end else begin
          case (phase_nxt)
            PH_H0: begin
              idl_nxt   = in_tdata;
              phase_nxt = PH_H1;
              fail      = in_tlast;
              fail_st   = ST_TRUNCATED;
            end
            PH_H1: begin
              idh_nxt   = in_tdata;
              phase_nxt = PH_H2;
              fail      = in_tlast;
              fail_st   = ST_TRUNCATED;
            end
            PH_H2: begin
              vh_nxt    = in_tdata;
              phase_nxt = PH_H3;
              fail      = in_tlast;
              fail_st   = ST_TRUNCATED;
            end
            PH_H3: begin
              phase_nxt   = PH_SEC;
              emit        = 1'b1;
              ent.kind    = REC_HEADER;
              ent.f0      = idl_r;
              ent.f1      = idh_r;
              ent.f2      = vh_r;
              ent.f3      = {8'h00, in_tdata};
              ent.eop     = in_tlast;
              stopped_nxt = in_tlast;
            end
            PH_SEC: begin
              sec_nxt   = in_tdata;
              rev_nxt   = '0;
              phase_nxt = PH_VER;
              if (in_tdata[3:0] != 4'h0 || in_tdata > SECTION_LAST) begin
                fail    = 1'b1;
                fail_st = ST_UNK_SECTION;
              end else begin
                fail    = in_tlast;
                fail_st = ST_TRUNCATED;
              end
            end
            PH_VER: begin
              rev_nxt = in_tdata;
              if (cnt_eff == 5'd0) begin
                fail    = 1'b1;
                fail_st = ST_UNK_VERSION;
              end else begin
                items_nxt = cnt_eff;
                tp_nxt    = grp.start;
                phase_nxt = PH_VHI;
                if (in_tlast) begin
                  fail    = 1'b1;
                  fail_st = ST_TRUNCATED;
                end else begin
                  emit     = 1'b1;
                  ent.kind = REC_SECTION;
                  ent.f0   = sec_r;
                  ent.f1   = in_tdata;
                end
              end
            end
            PH_VHI: begin
              vhb_nxt   = in_tdata;
              phase_nxt = PH_VLO;
              fail      = in_tlast;
              fail_st   = ST_TRUNCATED;
            end
            PH_VLO: begin
              items_nxt = items_r - 5'd1;
              tp_nxt    = tp_r + 8'd1;
              phase_nxt = (items_nxt != 5'd0) ? PH_VHI : PH_SEC;
              if (in_tlast && items_nxt != 5'd0) begin
                fail    = 1'b1;
                fail_st = ST_TRUNCATED;
              end else begin
                emit        = 1'b1;
                ent.kind    = REC_VALUE;
                ent.f0      = sec_r;
                ent.f1      = rev_r;
                ent.f2      = code;
                ent.f3      = {vhb_r, in_tdata};
                ent.eop     = in_tlast;
                stopped_nxt = in_tlast;
              end
            end
            default: begin
              phase_nxt = PH_H0;
            end
          endcase
        end
        // Error record carries the section fields as updated by this byte.
        if (fail) begin
          stopped_nxt = 1'b1;
          emit        = 1'b1;
          ent         = '0;
          ent.kind    = REC_END;
          ent.status  = fail_st;
          ent.eop     = 1'b1;
          ent.f0      = sec_nxt;
          ent.f1      = rev_nxt;
        end
      end
    end
  end

  assign q_push  = emit;
  assign q_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_H0;
      pos_r     <= '0;
      idl_r     <= '0;
      idh_r     <= '0;
      vh_r      <= '0;
      sec_r     <= '0;
      rev_r     <= '0;
      items_r   <= '0;
      tp_r      <= '0;
      vhb_r     <= '0;
      stopped_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      pos_r     <= pos_nxt;
      idl_r     <= idl_nxt;
      idh_r     <= idh_nxt;
      vh_r      <= vh_nxt;
      sec_r     <= sec_nxt;
      rev_r     <= rev_nxt;
      items_r   <= items_nxt;
      tp_r      <= tp_nxt;
      vhb_r     <= vhb_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

// ===== design/gpsp_queue.sv =====
module gpsp_queue import gpsp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  qentry_t push_data,
  output logic    full,
  input  logic    pop,
  output logic    valid,
  output qentry_t pop_data
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  qentry_t       mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r, count_nxt;

  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign valid    = (count_r != '0);
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      count_r <= count_nxt;
    end
  end

endmodule

// ===== design/gpsp_back.sv =====
module gpsp_back import gpsp_pkg::*; #(
  parameter int PROFILE_TYPES = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  qentry_t     q_entry,
  output logic        q_pop,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  localparam logic [3:0] TYPE_UNKNOWN = 4'(PROFILE_TYPES);

  logic        valid_r;
  logic [71:0] data_r, data_nxt;
  logic [1:0]  user_r;
  logic        last_r;

  logic [3:0]  ptype;
  logic [3:0]  vmaj, vmin;
  logic [7:0]  vpatch, sec, rev, icode;
  logic [15:0] raw;
  logic [6:0]  div;

  assign q_pop = q_valid && (!valid_r || out_tready);

  // Lowest matching row wins.
  always_comb begin
    ptype = TYPE_UNKNOWN;
    for (int i = TYPE_ROWS - 1; i >= 0; i--) begin
      if (i < PROFILE_TYPES && TYPE_IDS[i] == {q_entry.f0, q_entry.f1}) begin
        ptype = 4'(i);
      end
    end
  end

  always_comb begin
    vmaj   = '0;
    vmin   = '0;
    vpatch = '0;
    sec    = q_entry.f0;
    rev    = q_entry.f1;
    icode  = '0;
    raw    = '0;
    div    = '0;
    case (q_entry.kind)
      REC_HEADER: begin
        vmaj   = q_entry.f2[7:4];
        vmin   = q_entry.f2[3:0];
        vpatch = q_entry.f3[7:0];
        sec    = '0;
        rev    = '0;
      end
      REC_VALUE: begin
        icode = q_entry.f2;
        raw   = q_entry.f3;
        div   = divider_of(q_entry.f2);
      end
      default: begin
        icode = '0;
      end
    endcase
    data_nxt = {2'b00, q_entry.status, div, raw, icode, rev, sec, vpatch, vmin, vmaj,
                (q_entry.kind == REC_HEADER) ? ptype : 4'h0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= data_nxt;
      user_r <= q_entry.kind;
      last_r <= q_entry.eop;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tuser  = user_r;
  assign out_tlast  = last_r;

endmodule

// ===== design/grid_profile_section_parser.sv =====
// Channel  Dir  tdata                         tuser             tlast
// in_      in   payload byte                  first of profile  last of profile
// out_     out  record fields (see port)      record kind       end of profile
//
// One byte is taken every cycle while the queue is not full; the rate is
// set by the front state update, which handles a byte, its group or item
// lookup and its counters in one pass. A record enters the queue at the
// edge that accepts its byte and raises out_tvalid once the back pops it.
// Reset is synchronous, active low; there is no clearing pass.
// A four-entry queue decouples the parser from the output register; in_tready
// drops only while that queue is full.
module grid_profile_section_parser import gpsp_pkg::*; #(
  parameter int MAX_PROFILE_BYTES = 256,
  parameter int ITEM_TABLE_DEPTH  = 158,
  parameter int PROFILE_TYPES     = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] payload_byte
  input  logic        in_tuser,   // [0] first_of_profile
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [3:0] profile_type, [7:4] version_major, [11:8] version_minor,
  // [19:12] version_patch, [27:20] section_code, [35:28] section_revision,
  // [43:36] item_code, [59:44] raw_value, [66:60] divider, [69:67] status,
  // [71:70] zero
  output logic [71:0] out_tdata,
  output logic [1:0]  out_tuser,  // [1:0] record_kind
  output logic        out_tlast
);

  logic    q_push, q_full, q_pop, q_valid;
  qentry_t q_in, q_out;

  gpsp_front #(
    .MAX_PROFILE_BYTES (MAX_PROFILE_BYTES),
    .ITEM_TABLE_DEPTH  (ITEM_TABLE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_in)
  );

  gpsp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  gpsp_back #(
    .PROFILE_TYPES (PROFILE_TYPES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_entry    (q_out),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_push && q_full))
    else $error("record pushed into a full queue");

  a_status_only_on_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != REC_END |-> out_tdata[69:67] == ST_OK)
    else $error("error status on a non-end record");

  a_section_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == REC_SECTION |-> !out_tlast)
    else $error("section start closes the profile");

  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == REC_END |-> out_tlast)
    else $error("end record without end of profile");

endmodule

// ===== verif/grid_profile_section_parser_test.sv =====
module grid_profile_section_parser_test import gpsp_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_BYTES   = 256;
  localparam int N_TYPES     = 10;
  localparam int N_ROWS      = 158;
  localparam int RANDOM_REQS = 1500;
  localparam int IDLE_LIMIT  = 2000;
  localparam int TAIL_CYCLES = 20;

  // {id low, id high}
  localparam logic [15:0] PROFILE_IDS [N_TYPES] = '{
    16'h0200, 16'h0300, 16'h0301, 16'h0a00, 16'h0c00,
    16'h0d04, 16'h1000, 16'h1200, 16'h2900, 16'h3700
  };

  // scale divisor of item codes 0x01..0x41
  localparam logic [6:0] SCALE_DIV [65] = '{
    7'd10, 7'd10, 7'd10, 7'd10, 7'd10, 7'd10, 7'd100, 7'd10, 7'd100, 7'd10,
    7'd10, 7'd100, 7'd100, 7'd100, 7'd10, 7'd100, 7'd10, 7'd100, 7'd10, 7'd100,
    7'd10, 7'd1, 7'd10, 7'd10, 7'd10, 7'd100, 7'd100, 7'd100, 7'd100, 7'd1,
    7'd100, 7'd10, 7'd100, 7'd10, 7'd100, 7'd1, 7'd10, 7'd10, 7'd100, 7'd1,
    7'd100, 7'd1, 7'd10, 7'd10, 7'd10, 7'd10, 7'd10, 7'd10, 7'd10, 7'd1,
    7'd100, 7'd1, 7'd1, 7'd1, 7'd10, 7'd100, 7'd10, 7'd100, 7'd10, 7'd10,
    7'd10, 7'd100, 7'd100, 7'd10, 7'd10
  };

  // {section code, section version, item code}
  localparam logic [23:0] ITEM_MAP [N_ROWS] = '{
    24'h000001, 24'h000002, 24'h000003, 24'h000004, 24'h000005,
    24'h000101, 24'h000102, 24'h000103, 24'h000104, 24'h000105, 24'h000108, 24'h000109,
    24'h000201, 24'h000202, 24'h000203, 24'h000204, 24'h000205, 24'h000206, 24'h000207,
    24'h000301, 24'h000302, 24'h000303, 24'h000305, 24'h000306, 24'h000307, 24'h000308,
    24'h000309,
    24'h000801, 24'h000802, 24'h000803, 24'h000804, 24'h000805, 24'h0008ff,
    24'h000a01, 24'h000a02, 24'h000a03, 24'h000a04, 24'h000a05, 24'h000a06, 24'h000a07,
    24'h000a0a,
    24'h000b01, 24'h000b02, 24'h000b03, 24'h000b04, 24'h000b05, 24'h000b06, 24'h000b07,
    24'h000b08, 24'h000b09, 24'h000b0a,
    24'h000c01, 24'h000c02, 24'h000c03, 24'h000c04, 24'h000c05, 24'h000c06, 24'h000c07,
    24'h000c08, 24'h000c09, 24'h000c0b, 24'h000c0c, 24'h000c0a,
    24'h003501, 24'h003502, 24'h003503, 24'h003504, 24'h003505, 24'h003506, 24'h003507,
    24'h003508, 24'h003509, 24'h003539, 24'h00353a, 24'h00353b, 24'h00353c,
    24'h10000d, 24'h10000e, 24'h10000f, 24'h100010, 24'h100011,
    24'h10030d, 24'h10030e, 24'h10030f, 24'h100310, 24'h100311, 24'h100312, 24'h10033e,
    24'h100314, 24'h10033f,
    24'h200016,
    24'h300317, 24'h300318, 24'h300319, 24'h30031a, 24'h30031b,
    24'h300717, 24'h300718, 24'h300719, 24'h30071a, 24'h30071b, 24'h300740, 24'h300741,
    24'h40001c, 24'h40001d,
    24'h50001e, 24'h50001f, 24'h500020, 24'h500021,
    24'h50011e, 24'h50011f, 24'h500120, 24'h500121, 24'h500122,
    24'h50081e, 24'h50081f, 24'h500820, 24'h500821, 24'h500822, 24'h500823,
    24'h50111e, 24'h50111f, 24'h501120, 24'h501121, 24'h50113d,
    24'h600024, 24'h600025, 24'h600026, 24'h600027,
    24'h600424, 24'h600425, 24'h600426, 24'h600427,
    24'h700028,
    24'h700228, 24'h700229,
    24'h80002a, 24'h80002b, 24'h80002c, 24'h80002d, 24'h80002e, 24'h80002f, 24'h800030,
    24'h80012a, 24'h80012b, 24'h80012c, 24'h80012d, 24'h80012e, 24'h80012f, 24'h800130,
    24'h800131,
    24'h900032, 24'h900033,
    24'ha00234, 24'ha00235,
    24'hb00036, 24'hb00037, 24'hb00038
  };

  typedef enum logic [2:0] {
    P_ID_LOW, P_ID_HIGH, P_VERSION, P_PATCH, P_SECTION, P_REVISION, P_VALUE_HI, P_VALUE_LO
  } parse_phase_t;

  typedef enum int {
    PF_CLEAN, PF_TRUNCATED, PF_BAD_SECTION, PF_BAD_VERSION, PF_OPEN, PF_NOISE, PF_OVERFLOW
  } profile_style_t;

  // same bit order as {out_tuser, out_tlast, out_tdata}
  typedef struct packed {
    rec_kind_t   kind;
    logic        eop;
    logic [1:0]  pad;
    status_t     status;
    logic [6:0]  div;
    logic [15:0] raw;
    logic [7:0]  icode;
    logic [7:0]  rev;
    logic [7:0]  sec;
    logic [7:0]  vpatch;
    logic [3:0]  vminor;
    logic [3:0]  vmajor;
    logic [3:0]  ptype;
  } record_t;

  typedef struct packed {
    logic [7:0] b;
    logic       first;
    logic       last;
    logic       drain;
  } byte_req_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  byte_req_t   payload_reqs [$];
  record_t     expected_records [$];
  byte_req_t   next_req;
  record_t     got_rec;
  record_t     want_rec;
  logic        in_acc;
  logic        calm;
  int          send_gap;
  int          sink_stall;
  int          idle_cycles;
  int          mismatches;

  logic [7:0]  grp_sec [$];
  logic [7:0]  grp_ver [$];
  int          grp_len [$];

  // parser shadow state
  parse_phase_t parse_phase;
  logic [8:0]   byte_pos;
  logic [7:0]   id_low;
  logic [7:0]   id_high;
  logic [7:0]   version_byte;
  logic [7:0]   sec_code;
  logic [7:0]   sec_rev;
  logic [4:0]   items_due;
  logic [7:0]   row_ptr;
  logic [7:0]   value_hi;
  logic         parse_stopped;

  grid_profile_section_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void find_group(input logic [7:0] s, input logic [7:0] v,
                                     output logic [7:0] first_row, output logic [4:0] rows);
    first_row = '0;
    rows = '0;
    for (int i = 0; i < N_ROWS; i++) begin
      if (ITEM_MAP[i][23:16] == s && ITEM_MAP[i][15:8] == v) begin
        if (rows == 0) first_row = 8'(i);
        rows = rows + 5'd1;
      end
    end
  endfunction

  function automatic logic [3:0] profile_index();
    for (int i = 0; i < N_TYPES; i++) begin
      if (PROFILE_IDS[i] == {id_low, id_high}) return 4'(i);
    end
    return 4'(N_TYPES);
  endfunction

  function automatic logic [6:0] item_divider(input logic [7:0] code);
    if (code >= 8'h01 && code <= 8'h41) return SCALE_DIV[7'(code - 8'h01)];
    return 7'd1;
  endfunction

  function automatic record_t section_record(input rec_kind_t k, input status_t s,
                                             input logic e);
    record_t r;
    r = '0;
    r.kind = k;
    r.sec = sec_code;
    r.rev = sec_rev;
    r.status = s;
    r.eop = e;
    return r;
  endfunction

  task automatic add_expected(input record_t r);
    expected_records.insert(expected_records.size(), r);
  endtask

  task automatic clear_parser();
    parse_phase = P_ID_LOW;
    byte_pos = '0;
    id_low = '0;
    id_high = '0;
    version_byte = '0;
    sec_code = '0;
    sec_rev = '0;
    items_due = '0;
    row_ptr = '0;
    value_hi = '0;
    parse_stopped = 1'b0;
  endtask

  task automatic halt_parse(input status_t s);
    parse_stopped = 1'b1;
    add_expected(section_record(REC_END, s, 1'b1));
  endtask

  task automatic parse_payload_byte(input logic [7:0] b, input logic first, input logic last);
    record_t r;
    logic [8:0] p;
    logic [7:0] start_row;
    logic [4:0] rows;
    logic [7:0] code;
    if (first) clear_parser();
    if (parse_stopped) return;
    p = byte_pos;
    byte_pos = p + 9'd1;
    if (p >= MAX_BYTES) begin
      halt_parse(ST_OVERFLOW);
      return;
    end
    case (parse_phase)
      P_ID_LOW: begin
        id_low = b;
        parse_phase = P_ID_HIGH;
        if (last) halt_parse(ST_TRUNCATED);
      end
      P_ID_HIGH: begin
        id_high = b;
        parse_phase = P_VERSION;
        if (last) halt_parse(ST_TRUNCATED);
      end
      P_VERSION: begin
        version_byte = b;
        parse_phase = P_PATCH;
        if (last) halt_parse(ST_TRUNCATED);
      end
      P_PATCH: begin
        parse_phase = P_SECTION;
        r = '0;
        r.kind = REC_HEADER;
        r.ptype = profile_index();
        r.vmajor = version_byte[7:4];
        r.vminor = version_byte[3:0];
        r.vpatch = b;
        r.eop = last;
        if (last) parse_stopped = 1'b1;
        add_expected(r);
      end
      P_SECTION: begin
        sec_code = b;
        sec_rev = '0;
        parse_phase = P_REVISION;
        if (b[3:0] != 4'd0 || b > 8'hb0) halt_parse(ST_UNK_SECTION);
        else if (last) halt_parse(ST_TRUNCATED);
      end
      P_REVISION: begin
        sec_rev = b;
        find_group(sec_code, b, start_row, rows);
        if (rows == 0) begin
          halt_parse(ST_UNK_VERSION);
        end else begin
          items_due = rows;
          row_ptr = start_row;
          parse_phase = P_VALUE_HI;
          if (last) halt_parse(ST_TRUNCATED);
          else add_expected(section_record(REC_SECTION, ST_OK, 1'b0));
        end
      end
      P_VALUE_HI: begin
        value_hi = b;
        parse_phase = P_VALUE_LO;
        if (last) halt_parse(ST_TRUNCATED);
      end
      default: begin
        code = (row_ptr < N_ROWS) ? ITEM_MAP[row_ptr][7:0] : 8'hff;
        items_due = items_due - 5'd1;
        row_ptr = row_ptr + 8'd1;
        parse_phase = (items_due != 0) ? P_VALUE_HI : P_SECTION;
        if (last && items_due != 0) begin
          halt_parse(ST_TRUNCATED);
        end else begin
          r = section_record(REC_VALUE, ST_OK, last);
          r.icode = code;
          r.raw = {value_hi, b};
          r.div = item_divider(code);
          if (last) parse_stopped = 1'b1;
          add_expected(r);
        end
      end
    endcase
  endtask

  task automatic push_req(input logic [7:0] b, input logic first, input logic last,
                          input logic drain);
    byte_req_t q;
    q.b = b;
    q.first = first;
    q.last = last;
    q.drain = drain;
    payload_reqs = {payload_reqs, q};
  endtask

  function automatic logic [7:0] value_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'h7f;
      2: return 8'h80;
      3: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic queue_profile(input profile_style_t style, input logic drain);
    logic [7:0] pb [$];
    logic [7:0] s;
    logic [7:0] v;
    logic [7:0] start_row;
    logic [4:0] rows;
    int nsec;
    int g;
    int k;
    int cut;
    logic first;
    if (style == PF_NOISE) begin
      k = $urandom_range(1, 8);
      for (int i = 0; i < k; i++) begin
        push_req(8'($urandom), $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0,
                 drain && i == 0);
      end
      return;
    end
    if ($urandom_range(0, 4) != 0) begin
      k = $urandom_range(0, N_TYPES - 1);
      pb = {pb, PROFILE_IDS[k][15:8]};
      pb = {pb, PROFILE_IDS[k][7:0]};
    end else begin
      pb = {pb, 8'($urandom)};
      pb = {pb, 8'($urandom)};
    end
    pb = {pb, 8'($urandom)};
    pb = {pb, 8'($urandom)};
    nsec = (style == PF_OVERFLOW) ? 1000 : $urandom_range(0, 4);
    for (int i = 0; i < nsec; i++) begin
      if (style == PF_OVERFLOW && pb.size() >= MAX_BYTES + 3) break;
      g = $urandom_range(0, grp_sec.size() - 1);
      pb = {pb, grp_sec[g]};
      pb = {pb, grp_ver[g]};
      for (int j = 0; j < 2 * grp_len[g]; j++) pb = {pb, value_byte()};
    end
    if (style == PF_BAD_SECTION) begin
      do s = 8'($urandom); while (s[3:0] == 4'd0 && s <= 8'hb0);
      pb = {pb, s};
    end
    if (style == PF_BAD_VERSION) begin
      s = 8'($urandom_range(0, 11) * 16);
      do begin
        v = 8'($urandom);
        find_group(s, v, start_row, rows);
      end while (rows != 0);
      pb = {pb, s};
      pb = {pb, v};
    end
    // bytes after a stop must give nothing
    if (style == PF_BAD_SECTION || style == PF_BAD_VERSION) begin
      k = $urandom_range(0, 2);
      for (int i = 0; i < k; i++) pb = {pb, 8'($urandom)};
    end
    cut = pb.size() - 1;
    if (style == PF_TRUNCATED) cut = $urandom_range(0, pb.size() - 2);
    if (style == PF_OPEN) begin
      k = $urandom_range(1, pb.size());
      while (pb.size() > k) void'(pb.pop_back());
      cut = -1;
    end
    first = ($urandom_range(0, 9) != 0);
    for (int i = 0; i < pb.size(); i++) begin
      push_req(pb[i], first && i == 0, i == cut, drain && i == 0);
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // sender
  always @(negedge clk) begin
    if (rst_n && (!in_tvalid || in_acc)) begin
      if (send_gap != 0) begin
        send_gap = send_gap - 1;
        in_tvalid <= 1'b0;
      end else if (payload_reqs.size() == 0 ||
                   (payload_reqs[0].drain && expected_records.size() != 0)) begin
        in_tvalid <= 1'b0;
      end else begin
        next_req = payload_reqs.pop_front();
        in_tdata <= next_req.b;
        in_tuser <= next_req.first;
        in_tlast <= next_req.last;
        in_tvalid <= 1'b1;
        send_gap = pick_gap();
      end
    end
  end

  // receiver
  always @(negedge clk) begin
    if ($urandom_range(0, 299) == 0) calm <= !calm;
    if (rst_n) begin
      if (sink_stall != 0) begin
        sink_stall = sink_stall - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        sink_stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    in_acc <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got_rec = record_t'({out_tuser, out_tlast, out_tdata});
        if (expected_records.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected record: expected none, actual kind %0d tdata %h last %b",
                   $time, out_tuser, out_tdata, out_tlast);
        end else begin
          want_rec = expected_records.pop_front();
          check_field("record_kind", 16'(want_rec.kind), 16'(got_rec.kind));
          check_field("profile_type", 16'(want_rec.ptype), 16'(got_rec.ptype));
          check_field("version_major", 16'(want_rec.vmajor), 16'(got_rec.vmajor));
          check_field("version_minor", 16'(want_rec.vminor), 16'(got_rec.vminor));
          check_field("version_patch", 16'(want_rec.vpatch), 16'(got_rec.vpatch));
          check_field("section_code", 16'(want_rec.sec), 16'(got_rec.sec));
          check_field("section_revision", 16'(want_rec.rev), 16'(got_rec.rev));
          check_field("item_code", 16'(want_rec.icode), 16'(got_rec.icode));
          check_field("raw_value", want_rec.raw, got_rec.raw);
          check_field("divider", 16'(want_rec.div), 16'(got_rec.div));
          check_field("status", 16'(want_rec.status), 16'(got_rec.status));
          check_field("tdata_pad", 16'(want_rec.pad), 16'(got_rec.pad));
          check_field("end_of_profile", 16'(want_rec.eop), 16'(got_rec.eop));
        end
      end
      if (in_tvalid && in_tready) parse_payload_byte(in_tdata, in_tuser, in_tlast);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("grid_profile_section_parser regression: fail");
        $finish;
      end
    end
  end

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    in_acc = 1'b0;
    calm = 1'b0;
    send_gap = 0;
    sink_stall = 0;
    idle_cycles = 0;
    mismatches = 0;
    clear_parser();

    for (int i = 0; i < N_ROWS; i++) begin
      if (i == 0 || ITEM_MAP[i][23:8] != ITEM_MAP[i - 1][23:8]) begin
        grp_sec = {grp_sec, ITEM_MAP[i][23:16]};
        grp_ver = {grp_ver, ITEM_MAP[i][15:8]};
        grp_len = {grp_len, 1};
      end else begin
        grp_len[grp_len.size() - 1]++;
      end
    end

    // parse straight out of reset, no restart flag; extreme values, clean end
    push_req(8'h0d, 0, 0, 0);
    push_req(8'h04, 0, 0, 0);
    push_req(8'h12, 0, 0, 0);
    push_req(8'hff, 0, 0, 0);
    push_req(8'h70, 0, 0, 0);
    push_req(8'h02, 0, 0, 0);
    push_req(8'h80, 0, 0, 0);
    push_req(8'h00, 0, 0, 0);
    push_req(8'h7f, 0, 0, 0);
    push_req(8'hff, 0, 1, 0);
    // short header
    push_req(8'h00, 1, 1, 0);
    // header only, last profile type
    push_req(8'h37, 1, 0, 0);
    push_req(8'h00, 0, 0, 0);
    push_req(8'hf0, 0, 0, 0);
    push_req(8'h00, 0, 1, 0);
    // unknown profile id, then unknown section
    push_req(8'hff, 1, 0, 0);
    push_req(8'hff, 0, 0, 0);
    push_req(8'h00, 0, 0, 0);
    push_req(8'h00, 0, 0, 0);
    push_req(8'hb1, 0, 0, 0);
    // unknown version
    push_req(8'h02, 1, 0, 0);
    push_req(8'h00, 0, 0, 0);
    push_req(8'h00, 0, 0, 0);
    push_req(8'h00, 0, 0, 0);
    push_req(8'h00, 0, 0, 0);
    push_req(8'h36, 0, 0, 0);

    queue_profile(PF_CLEAN, 1'b1);
    while (payload_reqs.size() < RANDOM_REQS) begin
      if (payload_reqs.size() > RANDOM_REQS / 2 && payload_reqs.size() < RANDOM_REQS / 2 + 40)
        queue_profile(PF_OVERFLOW, 1'b1);
      else begin
        case ($urandom_range(0, 99)) inside
          [0:49]:  queue_profile(PF_CLEAN, $urandom_range(0, 19) == 0);
          [50:61]: queue_profile(PF_TRUNCATED, 1'b0);
          [62:69]: queue_profile(PF_BAD_SECTION, 1'b0);
          [70:77]: queue_profile(PF_BAD_VERSION, 1'b0);
          [78:89]: queue_profile(PF_OPEN, 1'b0);
          default: queue_profile(PF_NOISE, 1'b0);
        endcase
      end
    end

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (payload_reqs.size() != 0 || in_tvalid || expected_records.size() != 0);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (mismatches == 0) begin
      $display("grid_profile_section_parser regression: pass");
    end else begin
      $display("grid_profile_section_parser regression: fail");
    end
    $finish;
  end

endmodule
